[hdl/tcrc_pkg.sv]
// Shared types, constants and the CRC byte update for the triple CRC-16 block.
package tcrc_pkg;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'h0000;

	// One classified byte as it travels from the front end to the back end.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       odd;
	} item_t;

	// Reflected CRC-16 update over one byte, LSB first.
	function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] r;
		r = crc ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

[hdl/tcrc_front.sv]
// Front end: accepts bytes and tags each one with its position parity.
module tcrc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output logic                 push_valid,
	input  logic                 push_ready,
	output tcrc_pkg::item_t      push_item
);

	logic odd_q;
	logic accept;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	assign push_item.data = data_byte;
	assign push_item.last = last_byte;
	assign push_item.odd  = odd_q;

	// first byte of every message is odd
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_q <= 1'b1;
		end else if (accept) begin
			odd_q <= last_byte ? 1'b1 : !odd_q;
		end
	end

`ifndef SYNTHESIS
	a_parity_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> odd_q)
		else $error("parity not restarted after last byte");
`endif

endmodule

[hdl/tcrc_queue.sv]
// Short request queue between the front end and the back end.
module tcrc_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  tcrc_pkg::item_t      push_item,
	output logic                 head_valid,
	input  logic                 pop,
	output tcrc_pkg::item_t      head_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	tcrc_pkg::item_t  entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;

	assign push_ready = (count_q != CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
`endif

endmodule

[hdl/tcrc_back.sv]
// Back end: runs the three CRC registers and holds the result register.
module tcrc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  tcrc_pkg::item_t      head_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          crc_all,
	output logic [15:0]          crc_odd,
	output logic [15:0]          crc_even
);

	logic [15:0] all_q;
	logic [15:0] odd_q;
	logic [15:0] even_q;
	logic [15:0] all_nxt;
	logic [15:0] odd_nxt;
	logic [15:0] even_nxt;
	logic        out_valid_q;
	logic [15:0] crc_all_q;
	logic [15:0] crc_odd_q;
	logic [15:0] crc_even_q;

	// a last byte waits only while the result register is still full
	assign pop = head_valid && (!head_item.last || !out_valid_q || out_ready);

	always_comb begin
		all_nxt  = tcrc_pkg::crc_absorb(all_q, head_item.data);
		odd_nxt  = head_item.odd ? tcrc_pkg::crc_absorb(odd_q, head_item.data) : odd_q;
		even_nxt = head_item.odd ? even_q : tcrc_pkg::crc_absorb(even_q, head_item.data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_q       <= tcrc_pkg::CRC_INIT;
			odd_q       <= tcrc_pkg::CRC_INIT;
			even_q      <= tcrc_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head_item.last) begin
					all_q  <= tcrc_pkg::CRC_INIT;
					odd_q  <= tcrc_pkg::CRC_INIT;
					even_q <= tcrc_pkg::CRC_INIT;
				end else begin
					all_q  <= all_nxt;
					odd_q  <= odd_nxt;
					even_q <= even_nxt;
				end
			end
			if (pop && head_item.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_item.last) begin
			crc_all_q  <= all_nxt;
			crc_odd_q  <= odd_nxt;
			crc_even_q <= even_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_all   = crc_all_q;
	assign crc_odd   = crc_odd_q;
	assign crc_even  = crc_even_q;

`ifndef SYNTHESIS
	a_restart_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_item.last) |=> (all_q == '0 && odd_q == '0 && even_q == '0))
		else $error("CRC registers not cleared after last byte");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(pop && head_item.last))
		else $error("pending result overwritten");
`endif

endmodule

[hdl/triple_crc16_odd_even.sv]
// Triple CRC-16 (0xA001 reflected): whole message, odd-position and even-position bytes.
// Throughput: one byte per cycle (byte-wide CRC update) unless a last byte waits on a
// full result register. A last byte goes through the queue, then the result register.
// The queue (QUEUE_DEPTH entries) lets input keep flowing while a result waits.
// Reset (arst_n low, asynchronous): queue empty, CRC registers zero, next byte odd.
module triple_crc16_odd_even #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] crc_all,
	output logic [15:0] crc_odd,
	output logic [15:0] crc_even
);

	logic            push_valid;
	logic            push_ready;
	tcrc_pkg::item_t push_item;
	logic            head_valid;
	logic            pop;
	tcrc_pkg::item_t head_item;

	tcrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	tcrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.head_valid (head_valid),
		.pop        (pop),
		.head_item  (head_item)
	);

	tcrc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.crc_all    (crc_all),
		.crc_odd    (crc_odd),
		.crc_even   (crc_even)
	);

endmodule
